>>> rtl/rebd_pkg.sv
package rebd_pkg;

    // Result codes.
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_DOWN  = 3'd1;
    localparam logic [2:0] EV_UP    = 3'd2;
    localparam logic [2:0] EV_SHORT = 3'd3;
    localparam logic [2:0] EV_LONG  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DETENT     = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS = 2'd2;

    localparam logic [1:0]        PHASE_RESET = 2'd3;
    localparam logic signed [7:0] ACC_MAX     = 8'sd127;
    localparam logic signed [7:0] ACC_MIN     = -8'sd127;

    // Control for one quadrature-stage step.
    typedef struct packed {
        logic tick;
        logic poll;
        logic pin_a;
        logic pin_b;
    } quad_ctrl_t;

    // Transition table: row is the previous phase, column the new phase.
    function automatic logic signed [1:0] phase_delta(input logic [1:0] prev,
                                                      input logic [1:0] cur);
        logic signed [1:0] d;
        begin
            d = 2'sd0;
            case ({prev, cur})
                4'b00_01: d = -2'sd1;
                4'b00_10: d = 2'sd1;
                4'b01_00: d = 2'sd1;
                4'b01_11: d = -2'sd1;
                4'b10_00: d = -2'sd1;
                4'b10_11: d = 2'sd1;
                4'b11_01: d = 2'sd1;
                4'b11_10: d = -2'sd1;
                default:  d = 2'sd0;
            endcase
            return d;
        end
    endfunction

endpackage

>>> rtl/rebd_quad.sv
module rebd_quad (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  rebd_pkg::quad_ctrl_t ctrl,
    input  logic [3:0]         detent_steps,
    output logic [2:0]         rot_code
);
    import rebd_pkg::*;

    logic [1:0]        last_phase_reg, last_phase_next;
    logic signed [7:0] acc_reg, acc_next;
    logic [1:0]        phase;
    logic signed [1:0] delta;
    logic signed [7:0] base;
    logic signed [8:0] sum;
    logic signed [7:0] det;

    assign phase = {ctrl.pin_a, ctrl.pin_b};
    assign delta = phase_delta(last_phase_reg, phase);
    assign det   = $signed({4'd0, (detent_steps == 4'd0) ? 4'd1 : detent_steps});

    always_comb begin
        rot_code = EV_NONE;
        if (acc_reg >= det) begin
            rot_code = EV_DOWN;
        end else if (acc_reg <= -det) begin
            rot_code = EV_UP;
        end
    end

    always_comb begin
        // A reversal of direction starts the count over.
        if (acc_reg != 8'sd0 && ((delta > 2'sd0) != (acc_reg > 8'sd0))) begin
            base = 8'sd0;
        end else begin
            base = acc_reg;
        end
        sum = 9'(base) + 9'(delta);

        last_phase_next = last_phase_reg;
        acc_next        = acc_reg;
        if (step_en && ctrl.tick) begin
            last_phase_next = phase;
            if (delta != 2'sd0) begin
                if (sum > 9'(ACC_MAX)) begin
                    acc_next = ACC_MAX;
                end else if (sum < 9'(ACC_MIN)) begin
                    acc_next = ACC_MIN;
                end else begin
                    acc_next = sum[7:0];
                end
            end
        end else if (step_en && ctrl.poll && rot_code != EV_NONE) begin
            acc_next = 8'sd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_phase_reg <= PHASE_RESET;
            acc_reg        <= 8'sd0;
        end else begin
            last_phase_reg <= last_phase_next;
            acc_reg        <= acc_next;
        end
    end

endmodule

>>> rtl/rebd_button.sv
module rebd_button (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic        pressed,
    input  logic [31:0] now_ms,
    input  logic [15:0] debounce_time,
    input  logic [15:0] long_press_time,
    output logic [2:0]  btn_code
);
    import rebd_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PRESS_DB = 3'd1;
    localparam logic [2:0] ST_HELD     = 3'd2;
    localparam logic [2:0] ST_REL_DB   = 3'd3;
    localparam logic [2:0] ST_LONG     = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [31:0] edge_stamp_reg, edge_stamp_next;
    logic [31:0] press_stamp_reg, press_stamp_next;
    logic [31:0] since_edge, since_press;
    logic        debounced, long_held;

    // Elapsed times wrap modulo 2^32.
    assign since_edge  = now_ms - edge_stamp_reg;
    assign since_press = now_ms - press_stamp_reg;
    assign debounced   = since_edge >= {16'd0, debounce_time};
    assign long_held   = since_press >= {16'd0, long_press_time};

    always_comb begin
        state_next       = state_reg;
        edge_stamp_next  = edge_stamp_reg;
        press_stamp_next = press_stamp_reg;
        btn_code         = EV_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (pressed) begin
                    state_next      = ST_PRESS_DB;
                    edge_stamp_next = now_ms;
                end
            end
            ST_PRESS_DB: begin
                if (!pressed) begin
                    state_next = ST_IDLE;
                end else if (debounced) begin
                    state_next       = ST_HELD;
                    press_stamp_next = now_ms;
                end
            end
            ST_HELD: begin
                if (!pressed) begin
                    state_next      = ST_REL_DB;
                    edge_stamp_next = now_ms;
                end else if (long_held) begin
                    state_next = ST_LONG;
                    btn_code   = EV_LONG;
                end
            end
            ST_REL_DB: begin
                if (pressed) begin
                    state_next = ST_HELD;
                end else if (debounced) begin
                    state_next = ST_IDLE;
                    btn_code   = EV_SHORT;
                end
            end
            ST_LONG: begin
                if (!pressed) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            edge_stamp_reg  <= 32'd0;
            press_stamp_reg <= 32'd0;
        end else if (step_en) begin
            state_reg       <= state_next;
            edge_stamp_reg  <= edge_stamp_next;
            press_stamp_reg <= press_stamp_next;
        end
    end

endmodule

>>> rtl/rotary_encoder_button_decoder_top.sv
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_req_type, s_pin_a, s_pin_b, s_button_pressed, s_now_ms
// m_        m_valid / m_ready    m_event_code
// cfg_      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every accepted item yields exactly one result item: it passes through the input
// register and then the result register. The decoder state is updated as an item
// moves from the input register into the result register, so one item per cycle
// is sustained while the result side is not stalled.
// A stalled result register holds the input register, which then holds s_ready
// low. Reset (aresetn, synchronous, active low) empties both stages and loads
// the documented register and state values; no clearing pass is needed.
module rotary_encoder_button_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic        s_pin_a,
    input  logic        s_pin_b,
    input  logic        s_button_pressed,
    input  logic [31:0] s_now_ms,
    // Result items.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_code,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rebd_pkg::*;

    // Configuration registers.
    logic [3:0]  detent_reg;
    logic [15:0] debounce_reg;
    logic [15:0] long_press_reg;

    // Input register.
    logic        in_valid_reg;
    logic        req_type_reg;
    logic        pin_a_reg;
    logic        pin_b_reg;
    logic        pressed_reg;
    logic [31:0] now_reg;

    // Result register.
    logic        out_valid_reg;
    logic [2:0]  event_reg;
    logic [2:0]  event_next;

    logic        advance;
    logic        btn_step;
    quad_ctrl_t  qctrl;
    logic [2:0]  rot_code;
    logic [2:0]  btn_code;

    // The item in the input register moves on whenever the result register is
    // empty or is being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign qctrl.tick  = !req_type_reg;
    assign qctrl.poll  = req_type_reg;
    assign qctrl.pin_a = pin_a_reg;
    assign qctrl.pin_b = pin_b_reg;

    // A poll steps the button machine only when no rotation event is due.
    assign btn_step = advance && req_type_reg && (rot_code == EV_NONE);

    rebd_quad u_quad (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .ctrl         (qctrl),
        .detent_steps (detent_reg),
        .rot_code     (rot_code)
    );

    rebd_button u_button (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (btn_step),
        .pressed         (pressed_reg),
        .now_ms          (now_reg),
        .debounce_time   (debounce_reg),
        .long_press_time (long_press_reg),
        .btn_code        (btn_code)
    );

    // Sample ticks always report no event.
    always_comb begin
        if (!req_type_reg) begin
            event_next = EV_NONE;
        end else if (rot_code != EV_NONE) begin
            event_next = rot_code;
        end else begin
            event_next = btn_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detent_reg     <= 4'd4;
            debounce_reg   <= 16'd20;
            long_press_reg <= 16'd1000;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DETENT:     detent_reg     <= cfg_data[3:0];
                CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                CFG_LONG_PRESS: long_press_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg <= s_req_type;
            pin_a_reg    <= s_pin_a;
            pin_b_reg    <= s_pin_b;
            pressed_reg  <= s_button_pressed;
            now_reg      <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            event_reg <= event_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_code = event_reg;

endmodule
